@@ rtl/core/tcw_pkg.sv @@
`default_nettype none

package tcw_pkg;

    // Cell layout: attribute byte above the character byte
    localparam int CELL_W = 16;

    localparam logic [7:0] ATTR_RESET   = 8'h0F;
    localparam logic [7:0] BLANK_CHAR   = 8'h20;
    localparam logic [7:0] NEWLINE_CHAR = 8'h0A;

    // Operation codes
    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  char_code;
        logic [10:0] cell_address;
    } in_t;

    typedef struct packed {
        logic [6:0]        cursor_col;
        logic [4:0]        cursor_row;
        logic [CELL_W-1:0] cell_value;
        logic              scrolled;
    } out_t;

    // Sequencer status towards the channel logic
    typedef struct packed {
        logic idle;
        logic res_valid;
    } ctl_status_t;

endpackage

`default_nettype wire

@@ rtl/core/tcw_screen_ram.sv @@
`default_nettype none

module tcw_screen_ram #(
    parameter int DEPTH = 2000,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                        clk,
    input  wire logic                        we,
    input  wire logic [AW-1:0]               waddr,
    input  wire logic [tcw_pkg::CELL_W-1:0]  wdata,
    input  wire logic                        re,
    input  wire logic [AW-1:0]               raddr,
    output logic      [tcw_pkg::CELL_W-1:0]  rdata
);

    logic [tcw_pkg::CELL_W-1:0] mem [DEPTH];
    logic [tcw_pkg::CELL_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/core/tcw_ctrl.sv @@
`default_nettype none

module tcw_ctrl #(
    parameter  int COLUMNS = 80,
    parameter  int ROWS    = 25,
    localparam int CELLS   = COLUMNS * ROWS,
    localparam int AW      = (CELLS > 1) ? $clog2(CELLS) : 1
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    input  wire tcw_pkg::in_t                in_word,
    input  wire logic [7:0]                  attribute,
    input  wire logic                        res_ready,
    output tcw_pkg::ctl_status_t             status,
    output tcw_pkg::out_t                    res,
    output logic                             ram_we,
    output logic      [AW-1:0]               ram_waddr,
    output logic      [tcw_pkg::CELL_W-1:0]  ram_wdata,
    output logic                             ram_re,
    output logic      [AW-1:0]               ram_raddr,
    input  wire logic [tcw_pkg::CELL_W-1:0]  ram_rdata
);

    localparam int CW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int RW = $clog2(ROWS);

    localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
    localparam logic [AW-1:0] SRC_COUNT = AW'(CELLS - COLUMNS);
    localparam logic [AW-1:0] ROW_STEP  = AW'(COLUMNS);
    localparam logic [CW-1:0] COL_LAST  = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);

    typedef enum logic [5:0] {
        S_INIT   = 6'b000001,
        S_IDLE   = 6'b000010,
        S_READ   = 6'b000100,
        S_SCROLL = 6'b001000,
        S_FILL   = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic              pend_reg, pend_next;
    logic [AW-1:0]     pend_addr_reg, pend_addr_next;
    logic [CW-1:0]     col_reg, col_next;
    logic [RW-1:0]     line_reg, line_next;
    logic [tcw_pkg::CELL_W-1:0] res_cell_reg, res_cell_next;
    logic              res_scr_reg, res_scr_next;

    logic              accept;
    logic              addr_ok;
    logic              col_end;
    logic [AW-1:0]     cursor_pos;

    assign accept     = in_valid && (state_reg == S_IDLE);
    assign addr_ok    = 32'(in_word.cell_address) < CELLS;
    assign col_end    = (in_word.char_code == tcw_pkg::NEWLINE_CHAR) || (col_reg == COL_LAST);
    assign cursor_pos = AW'(32'(line_reg) * COLUMNS) + AW'(col_reg);

    // Sequencer: one address step of the shared sweep counter per cycle
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        col_next       = col_reg;
        line_next      = line_reg;
        res_cell_next  = res_cell_reg;
        res_scr_next   = res_scr_reg;
        ram_we         = 1'b0;
        ram_waddr      = idx_reg;
        ram_wdata      = {attribute, tcw_pkg::BLANK_CHAR};
        ram_re         = 1'b0;
        ram_raddr      = idx_reg + ROW_STEP;

        unique case (state_reg)
            S_INIT:
            begin
                ram_we    = 1'b1;
                ram_wdata = {tcw_pkg::ATTR_RESET, tcw_pkg::BLANK_CHAR};
                if (idx_reg == LAST_CELL)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                end
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    res_cell_next = '0;
                    res_scr_next  = 1'b0;
                    case (in_word.op)
                        tcw_pkg::OP_PUT:
                        begin
                            if (in_word.char_code != tcw_pkg::NEWLINE_CHAR)
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = cursor_pos;
                                ram_wdata = {attribute, in_word.char_code};
                            end
                            if (col_end)
                            begin
                                col_next = '0;
                                if (line_reg == ROW_LAST)
                                begin
                                    res_scr_next = 1'b1;
                                    idx_next     = '0;
                                    state_next   = S_SCROLL;
                                end
                                else
                                begin
                                    line_next  = line_reg + RW'(1);
                                    state_next = S_DONE;
                                end
                            end
                            else
                            begin
                                col_next   = col_reg + CW'(1);
                                state_next = S_DONE;
                            end
                        end
                        tcw_pkg::OP_READ:
                        begin
                            if (addr_ok)
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = AW'(in_word.cell_address);
                                state_next = S_READ;
                            end
                            else
                            begin
                                state_next = S_DONE;
                            end
                        end
                        tcw_pkg::OP_CLEAR:
                        begin
                            col_next   = '0;
                            line_next  = '0;
                            idx_next   = '0;
                            state_next = S_FILL;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_READ:
            begin
                res_cell_next = ram_rdata;
                state_next    = S_DONE;
            end

            // Copy each cell one row up: read ahead, write the previous word
            S_SCROLL:
            begin
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pend_addr_reg;
                    ram_wdata = ram_rdata;
                end
                if (idx_reg != SRC_COUNT)
                begin
                    ram_re         = 1'b1;
                    pend_next      = 1'b1;
                    pend_addr_next = idx_reg;
                    idx_next       = idx_reg + AW'(1);
                end
                else
                begin
                    // index now points at the start of the bottom row
                    state_next = S_FILL;
                end
            end

            S_FILL:
            begin
                ram_we = 1'b1;
                if (idx_reg == LAST_CELL)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                end
            end

            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            idx_reg   <= '0;
            pend_reg  <= 1'b0;
            col_reg   <= '0;
            line_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            pend_reg  <= pend_next;
            col_reg   <= col_next;
            line_reg  <= line_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pend_addr_reg <= pend_addr_next;
        res_cell_reg  <= res_cell_next;
        res_scr_reg   <= res_scr_next;
    end

    assign status.idle      = (state_reg == S_IDLE);
    assign status.res_valid = (state_reg == S_DONE);

    assign res.cursor_col = 7'(col_reg);
    assign res.cursor_row = 5'(line_reg);
    assign res.cell_value = res_cell_reg;
    assign res.scrolled   = res_scr_reg;

`ifndef NO_ASSERTIONS
    a_no_stray_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && !accept) |-> !ram_we)
        else $error("screen store written while idle");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && !res_ready) |=> (state_reg == S_DONE))
        else $error("result dropped before it was taken");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(col_reg) < COLUMNS) && (32'(line_reg) < ROWS))
        else $error("cursor outside the screen");

    a_scroll_at_bottom: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCROLL) |-> (line_reg == ROW_LAST && col_reg == '0))
        else $error("scroll with cursor off the bottom row start");
`endif

endmodule

`default_nettype wire

@@ rtl/core/text_console_writer_unit.sv @@
`default_nettype none

// Text console writer: a COLUMNS x ROWS screen store of 16-bit cells and a cursor.
// Input channel (in_valid/in_stall/in_word): op put, read or clear, with a
// character byte and a cell address. Output channel (out_valid/out_stall/out_word):
// one word per input word with the cursor afterwards, the cell read and a scroll flag.
// Config channel (cfg_valid/cfg_ready/cfg_data): the attribute byte, always ready;
// write it only while the block is idle.
// Sequencing, one item at a time through one sweep counter and one RAM port pair; an
// item's result word can be taken at the same edge as the next input word:
//   put without scroll: IDLE, then DONE; read: IDLE, READ, then DONE;
//   put that scrolls: copy of each cell below the top row one row up
//   through the single read and write port, then the bottom row fill;
//   clear: every cell filled with blanks, one cell written per cycle.
// Reset: cursor homes, attribute becomes 0x0F and a clearing pass writes blanks
// to all COLUMNS*ROWS cells, one per cycle; in_stall stays high meanwhile, config
// writes are still taken.
// A stalled receiver holds the output register; the next input word is still
// accepted and worked on, and its result waits until the register frees.

module text_console_writer_unit #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire tcw_pkg::in_t  in_word,
    output logic               out_valid,
    input  wire logic          out_stall,
    output tcw_pkg::out_t      out_word,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [7:0]    cfg_data
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

    logic [7:0]                 attr_reg;
    logic                       out_valid_reg;
    tcw_pkg::out_t              out_word_reg;
    logic                       res_ready;
    tcw_pkg::ctl_status_t       status;
    tcw_pkg::out_t              res;
    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [tcw_pkg::CELL_W-1:0] ram_wdata;
    logic                       ram_re;
    logic [AW-1:0]              ram_raddr;
    logic [tcw_pkg::CELL_W-1:0] ram_rdata;

    assign cfg_ready = 1'b1;
    assign in_stall  = !status.idle;
    assign res_ready = !out_valid_reg || !out_stall;

    // Attribute register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= tcw_pkg::ATTR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            attr_reg <= cfg_data;
        end
    end

    // Output register: load a finished result, drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (status.res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (status.res_valid && res_ready)
        begin
            out_word_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    tcw_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_word   (in_word),
        .attribute (attr_reg),
        .res_ready (res_ready),
        .status    (status),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    tcw_screen_ram #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

`default_nettype wire

@@ sim/console_checker.sv @@
`default_nettype none

module console_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic          in_stall,
    input  wire tcw_pkg::in_t  in_word,
    input  wire logic          out_valid,
    input  wire logic          out_stall,
    input  wire tcw_pkg::out_t out_word,
    input  wire logic          cfg_valid,
    input  wire logic          cfg_ready,
    input  wire logic [7:0]    cfg_data,
    output int                 report_errors,
    output int                 reports_awaited
);

    localparam int CELLS = COLUMNS * ROWS;

    // Shadow copy of the screen, cursor and attribute register
    logic [15:0] shadow_cells [CELLS];
    int          shadow_col;
    int          shadow_row;
    logic [7:0]  shadow_attr;

    tcw_pkg::out_t awaited_reports [$];

    initial report_errors = 0;
    initial reports_awaited = 0;

    function automatic void blank_screen();
        for (int i = 0; i < CELLS; i++)
        begin
            shadow_cells[i] = {shadow_attr, tcw_pkg::BLANK_CHAR};
        end
    endfunction

    // Move to the start of the next row; scroll when already on the last one
    function automatic logic next_line();
        shadow_col = 0;
        if (shadow_row + 1 < ROWS)
        begin
            shadow_row = shadow_row + 1;
            return 1'b0;
        end
        shadow_row = ROWS - 1;
        for (int i = 0; i + COLUMNS < CELLS; i++)
        begin
            shadow_cells[i] = shadow_cells[i + COLUMNS];
        end
        for (int i = CELLS - COLUMNS; i < CELLS; i++)
        begin
            shadow_cells[i] = {shadow_attr, tcw_pkg::BLANK_CHAR};
        end
        return 1'b1;
    endfunction

    // Apply one input word to the shadow console and form its report
    function automatic tcw_pkg::out_t console_step(tcw_pkg::in_t w);
        tcw_pkg::out_t r;
        int            pos;
        r = '0;
        case (w.op)
            tcw_pkg::OP_PUT:
            begin
                if (w.char_code == tcw_pkg::NEWLINE_CHAR)
                begin
                    r.scrolled = next_line();
                end
                else
                begin
                    pos = shadow_row * COLUMNS + shadow_col;
                    if (pos < CELLS)
                    begin
                        shadow_cells[pos] = {shadow_attr, w.char_code};
                    end
                    shadow_col = shadow_col + 1;
                    if (shadow_col >= COLUMNS)
                    begin
                        r.scrolled = next_line();
                    end
                end
            end
            tcw_pkg::OP_READ:
            begin
                if (int'(w.cell_address) < CELLS)
                begin
                    r.cell_value = shadow_cells[w.cell_address];
                end
            end
            tcw_pkg::OP_CLEAR:
            begin
                blank_screen();
                shadow_col = 0;
                shadow_row = 0;
            end
            default:
            begin
            end
        endcase
        r.cursor_col = shadow_col[6:0];
        r.cursor_row = shadow_row[4:0];
        return r;
    endfunction

    // Track config, predict each accepted word, compare each delivered report
    always @(posedge clk or negedge rst_n)
    begin
        tcw_pkg::out_t want;
        if (!rst_n)
        begin
            shadow_attr = tcw_pkg::ATTR_RESET;
            shadow_col  = 0;
            shadow_row  = 0;
            blank_screen();
            awaited_reports.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                shadow_attr = cfg_data;
            end
            if (in_valid && !in_stall)
            begin
                awaited_reports.push_back(console_step(in_word));
            end
            if (out_valid && !out_stall)
            begin
                if (awaited_reports.size() == 0)
                begin
                    $error("report word arrived with nothing awaited");
                    report_errors++;
                end
                else
                begin
                    want = awaited_reports.pop_front();
                    if (out_word.cursor_col !== want.cursor_col)
                    begin
                        $error("cursor_col: expected %0d, got %0d",
                               want.cursor_col, out_word.cursor_col);
                        report_errors++;
                    end
                    if (out_word.cursor_row !== want.cursor_row)
                    begin
                        $error("cursor_row: expected %0d, got %0d",
                               want.cursor_row, out_word.cursor_row);
                        report_errors++;
                    end
                    if (out_word.cell_value !== want.cell_value)
                    begin
                        $error("cell_value: expected %h, got %h",
                               want.cell_value, out_word.cell_value);
                        report_errors++;
                    end
                    if (out_word.scrolled !== want.scrolled)
                    begin
                        $error("scrolled: expected %0d, got %0d",
                               want.scrolled, out_word.scrolled);
                        report_errors++;
                    end
                end
            end
        end
        reports_awaited = awaited_reports.size();
    end

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
`default_nettype none

module testbench;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int PHASES      = 8;
    localparam int PHASE_WORDS = 135;
    localparam int LONG_HOLD   = 400;
    // Slowest item is a full-store sweep plus both sides' longest idle bursts
    localparam longint CYCLE_LIMIT = 12_000_000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic          in_valid = 1'b0;
    logic          in_stall;
    tcw_pkg::in_t  in_word = '0;
    logic          out_valid;
    logic          out_stall = 1'b0;
    tcw_pkg::out_t out_word;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [7:0]    cfg_data = '0;

    int     report_errors;
    int     reports_awaited;
    int     words_sent = 0;
    logic   hold_request = 1'b0;
    logic   calm = 1'b0;
    longint cycle_count = 0;

    text_console_writer_unit #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    console_checker #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .in_word         (in_word),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_word        (out_word),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .report_errors   (report_errors),
        .reports_awaited (reports_awaited)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Offer one word, with an occasional idle burst ahead of it
    task automatic send_word(input logic [1:0] op, input logic [7:0] ch,
                             input logic [10:0] addr);
        tcw_pkg::in_t w;
        w.op           = op;
        w.char_code    = ch;
        w.cell_address = addr;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        words_sent++;
    endtask

    task automatic put_char(input logic [7:0] ch);
        send_word(tcw_pkg::OP_PUT, ch, 11'($urandom_range(0, 2047)));
    endtask

    task automatic read_cell(input logic [10:0] addr);
        send_word(tcw_pkg::OP_READ, 8'($urandom_range(0, 255)), addr);
    endtask

    task automatic clear_screen();
        send_word(tcw_pkg::OP_CLEAR, 8'($urandom_range(0, 255)),
                  11'($urandom_range(0, 2047)));
    endtask

    // Drop valid, wait for every report, then let any sweep finish
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (reports_awaited != 0) @(posedge clk);
        repeat (CELLS + 16) @(posedge clk);
    endtask

    task automatic write_attribute(input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Pick a read address: mostly on screen, sometimes past the store
    function automatic logic [10:0] pick_address();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return 11'($urandom_range(0, CELLS - 1));
        if (r < 8) return 11'($urandom_range(CELLS - COLUMNS, CELLS - 1));
        if (r == 8) return 11'($urandom_range(0, COLUMNS - 1));
        return 11'($urandom_range(CELLS, 2047));
    endfunction

    // One random stretch of console traffic
    task automatic random_burst();
        int kind;
        int n;
        kind = $urandom_range(0, 99);
        if (kind < 50)
        begin
            // a line of text, sometimes long enough to wrap
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(70, 100) : $urandom_range(0, 12);
            for (int i = 0; i < n; i++)
            begin
                put_char(8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 3) != 0) put_char(tcw_pkg::NEWLINE_CHAR);
        end
        else if (kind < 70)
        begin
            n = $urandom_range(1, 40);
            for (int i = 0; i < n; i++)
            begin
                put_char(tcw_pkg::NEWLINE_CHAR);
            end
        end
        else if (kind < 92)
        begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
            begin
                read_cell(pick_address());
            end
        end
        else if (kind < 94)
        begin
            clear_screen();
        end
        else
        begin
            send_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                      11'($urandom_range(0, 2047)));
        end
    endtask

    // Receiver: random stall bursts, clean stretches and one long hold
    initial
    begin
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                hold_request = 1'b0;
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                repeat (($urandom_range(0, 9) == 0) ? 40 : 1) @(posedge clk);
            end
        end
    end

    // Guard against a hang
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        logic [7:0] attr;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset contents, field extremes, newline, unused op and clear
        read_cell(11'd0);
        read_cell(11'd1999);
        read_cell(11'd2047);
        read_cell(11'd2000);
        put_char(8'h00);
        put_char(8'hFF);
        put_char(tcw_pkg::NEWLINE_CHAR);
        put_char(tcw_pkg::BLANK_CHAR);
        read_cell(11'd0);
        read_cell(11'd1);
        read_cell(11'd80);
        send_word(OP_UNUSED, 8'hFF, 11'h7FF);
        clear_screen();
        read_cell(11'd0);
        settle();

        write_attribute(8'hFF);
        put_char(8'h5A);
        put_char(8'hA5);
        read_cell(11'd0);
        read_cell(11'd1);
        clear_screen();
        read_cell(11'd1999);
        settle();

        write_attribute(8'h00);
        put_char(8'h41);
        read_cell(11'd0);

        // Random phases, each under its own attribute
        for (int p = 0; p < PHASES; p++)
        begin
            if (p > 0)
            begin
                settle();
                attr = (p == 3) ? 8'hFF :
                       (p == 5) ? tcw_pkg::ATTR_RESET : 8'($urandom_range(0, 255));
                write_attribute(attr);
            end
            if (p == 2) hold_request = 1'b1;
            if (p == PHASES - 1) calm = 1'b1;
            words_sent = 0;
            while (words_sent < PHASE_WORDS) random_burst();
        end

        settle();
        if (report_errors == 0 && reports_awaited == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/core/tcw_pkg.sv
rtl/core/tcw_screen_ram.sv
rtl/core/tcw_ctrl.sv
rtl/core/text_console_writer_unit.sv
sim/console_checker.sv
sim/testbench.sv
